@@ hdl/lfu_pkg.sv @@
// Shared types and constants for the LFU key-value table.
// No dependencies; every other file of the block but lfu_ram imports this package.
package lfu_pkg;

	// Fixed widths of the request, response and configuration fields
	localparam int ACTION_W  = 1;
	localparam int KEY_W     = 64;
	localparam int DATA_W    = 64;
	localparam int EVICT_W   = 5;
	localparam int CFG_W     = 5;

	// Request kinds
	localparam logic [ACTION_W-1:0] ACT_GET = 1'b0;
	localparam logic [ACTION_W-1:0] ACT_SET = 1'b1;

	// Capacity after reset
	localparam logic [CFG_W-1:0] CAPACITY_RST = 5'd16;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_EVICT,
		ST_WRITE,
		ST_FINISH
	} state_t;

endpackage

@@ hdl/lfu_ifs.sv @@
// Valid/ready channel interfaces: request, response and capacity write.
// Depends on lfu_pkg for the field widths.
interface lfu_req_if;
	import lfu_pkg::*;
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [KEY_W-1:0]    key;
	logic [DATA_W-1:0]   value;
	modport source (output valid, action, key, value, input ready);
	modport sink (input valid, action, key, value, output ready);
endinterface

interface lfu_rsp_if;
	import lfu_pkg::*;
	logic               valid;
	logic               ready;
	logic               found;
	logic [DATA_W-1:0]  read_value;
	logic [EVICT_W-1:0] evicted_count;
	modport source (output valid, found, read_value, evicted_count, input ready);
	modport sink (input valid, found, read_value, evicted_count, output ready);
endinterface

interface lfu_cfg_if;
	import lfu_pkg::*;
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

@@ hdl/lfu_cache_group_evict_unit.sv @@
// LFU table: one request at a time, entries (key, value, count) held in one RAM.
// Each request scans the whole RAM, one entry per cycle, then decides; a set that must
// evict runs a second scan, and a get hit or a set of a new key ends with a RAM write.
// A new request is accepted only once the last response is loaded into the output
// register; a response still stalled when the next one is due holds the sequencer.
// Reset (arst_n low, asynchronous) empties the table and sets capacity to 16.
module lfu_cache_group_evict_unit #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 64,
	parameter int VALUE_BITS = 64,
	parameter int COUNT_BITS = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	lfu_req_if.sink   req,
	lfu_rsp_if.source rsp,
	lfu_cfg_if.sink   cfg
);
	import lfu_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int CAP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int RAM_W = KEY_BITS + VALUE_BITS + COUNT_BITS;
	localparam logic [IDX_W-1:0]      LAST_IDX    = IDX_W'(ENTRIES - 1);
	localparam logic [CNT_W-1:0]      ENTRIES_CNT = CNT_W'(ENTRIES);
	localparam logic [COUNT_BITS-1:0] CNT_MAX     = '1;
	localparam logic [COUNT_BITS-1:0] CNT_ONE     = COUNT_BITS'(1);

	// control state
	state_t               state_q, state_d;
	logic [ENTRIES-1:0]   valid_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 rd_s1;
	logic                 hit_q;
	logic                 free_q;
	logic                 out_valid_q;
	logic [CFG_W-1:0]     capacity_q;

	// request and scan results
	logic [ACTION_W-1:0]   act_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [IDX_W-1:0]      idx_s1;
	logic [IDX_W-1:0]      hit_idx_q;
	logic [VALUE_BITS-1:0] hit_val_q;
	logic [COUNT_BITS-1:0] hit_cnt_q;
	logic [IDX_W-1:0]      free_idx_q;
	logic [CNT_W-1:0]      used_q;
	logic [COUNT_BITS-1:0] min_q;
	logic [CNT_W-1:0]      evict_q;

	// output register
	logic               out_found_q;
	logic [DATA_W-1:0]  out_rdval_q;
	logic [EVICT_W-1:0] out_evict_q;

	// RAM ports
	logic              ram_we, ram_re;
	logic [IDX_W-1:0]  ram_waddr;
	logic [RAM_W-1:0]  ram_wdata, ram_rdata;

	// decoded control
	logic                  req_acc;
	logic                  load_out;
	logic                  last;
	logic                  ent_vld;
	logic [KEY_BITS-1:0]   ent_key;
	logic [VALUE_BITS-1:0] ent_val;
	logic [COUNT_BITS-1:0] ent_cnt;
	logic                  ent_min;
	logic [CAP_W-1:0]      cap_raw, cap_eff;
	logic                  full;
	logic [COUNT_BITS-1:0] hit_cnt_inc;

	lfu_ram #(
		.WIDTH (RAM_W),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (cnt_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	// entry returned by the RAM in the cycle after its read
	assign ent_key = ram_rdata[RAM_W-1 -: KEY_BITS];
	assign ent_val = ram_rdata[COUNT_BITS +: VALUE_BITS];
	assign ent_cnt = ram_rdata[COUNT_BITS-1:0];
	assign ent_vld = valid_q[idx_s1];
	assign ent_min = ent_vld && (ent_cnt == min_q);
	assign last    = rd_s1 && (idx_s1 == LAST_IDX);

	// effective capacity: 0 acts as 1, anything above the table size as the size
	assign cap_raw = CAP_W'(capacity_q);
	always_comb begin
		if (capacity_q == '0) begin
			cap_eff = CAP_W'(1);
		end else if (cap_raw > CAP_W'(ENTRIES)) begin
			cap_eff = CAP_W'(ENTRIES);
		end else begin
			cap_eff = cap_raw;
		end
	end
	assign full = CAP_W'(used_q) >= cap_eff;

	assign hit_cnt_inc = (hit_cnt_q == CNT_MAX) ? hit_cnt_q : hit_cnt_q + CNT_ONE;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (last) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (act_q == ACT_GET) begin
					state_d = hit_q ? ST_WRITE : ST_FINISH;
				end else if (hit_q) begin
					state_d = ST_FINISH;
				end else if (full) begin
					state_d = ST_EVICT;
				end else begin
					state_d = free_q ? ST_WRITE : ST_FINISH;
				end
			end
			ST_EVICT: begin
				// the last entry may itself be the first one freed
				if (last) begin
					state_d = (free_q || !ent_vld || ent_min) ? ST_WRITE : ST_FINISH;
				end
			end
			ST_WRITE: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || rsp.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		req.ready = 1'b0;
		ram_re    = 1'b0;
		ram_we    = 1'b0;
		load_out  = 1'b0;
		ram_waddr = free_idx_q;
		ram_wdata = {key_q, val_q, CNT_ONE};
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
			end
			ST_SCAN, ST_EVICT: begin
				ram_re = (cnt_q != ENTRIES_CNT);
			end
			ST_WRITE: begin
				ram_we = 1'b1;
				if (act_q == ACT_GET) begin
					ram_waddr = hit_idx_q;
					ram_wdata = {key_q, hit_val_q, hit_cnt_inc};
				end
			end
			ST_FINISH: begin
				load_out = !out_valid_q || rsp.ready;
			end
			default: begin
				req.ready = 1'b0;
			end
		endcase
	end

	assign req_acc = req.valid && req.ready;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			cnt_q       <= '0;
			rd_s1       <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			out_valid_q <= 1'b0;
			capacity_q  <= CAPACITY_RST;
		end else begin
			state_q <= state_d;
			rd_s1   <= ram_re;
			if (cfg.valid) begin
				capacity_q <= cfg.data;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (ram_re) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			// start of a request: clear the scan flags
			if (req_acc) begin
				cnt_q  <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end
			// first pass: hit search and lowest free entry
			if (state_q == ST_SCAN && rd_s1) begin
				if (ent_vld && ent_key == key_q) begin
					hit_q <= 1'b1;
				end
				if (!ent_vld) begin
					free_q <= 1'b1;
				end
			end
			// eviction pass restarts the scan and the free search
			if (state_q == ST_DECIDE) begin
				cnt_q  <= '0;
				free_q <= 1'b0;
			end
			if (state_q == ST_EVICT && rd_s1) begin
				if (ent_min) begin
					valid_q[idx_s1] <= 1'b0;
				end
				if (!ent_vld || ent_min) begin
					free_q <= 1'b1;
				end
			end
			// a new key occupies its entry
			if (state_q == ST_WRITE && act_q == ACT_SET) begin
				valid_q[free_idx_q] <= 1'b1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[IDX_W-1:0];
		if (req_acc) begin
			act_q   <= req.action;
			key_q   <= req.key[KEY_BITS-1:0];
			val_q   <= req.value[VALUE_BITS-1:0];
			used_q  <= '0;
			min_q   <= CNT_MAX;
			evict_q <= '0;
		end
		if (state_q == ST_SCAN && rd_s1) begin
			if (ent_vld) begin
				used_q <= used_q + CNT_W'(1);
				if (ent_cnt < min_q) begin
					min_q <= ent_cnt;
				end
				if (ent_key == key_q && !hit_q) begin
					hit_idx_q <= idx_s1;
					hit_val_q <= ent_val;
					hit_cnt_q <= ent_cnt;
				end
			end else if (!free_q) begin
				free_idx_q <= idx_s1;
			end
		end
		if (state_q == ST_EVICT && rd_s1) begin
			if (ent_min) begin
				evict_q <= evict_q + CNT_W'(1);
			end
			if ((!ent_vld || ent_min) && !free_q) begin
				free_idx_q <= idx_s1;
			end
		end
		// response register
		if (load_out) begin
			out_found_q <= hit_q;
			out_rdval_q <= (act_q == ACT_GET && hit_q) ? DATA_W'(hit_val_q) : '0;
			out_evict_q <= EVICT_W'(evict_q);
		end
	end

	assign cfg.ready         = 1'b1;
	assign rsp.valid         = out_valid_q;
	assign rsp.found         = out_found_q;
	assign rsp.read_value    = out_rdval_q;
	assign rsp.evicted_count = out_evict_q;

endmodule

@@ hdl/lfu_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lfu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic                                          re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port, and read port with registered read data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hdl/lfu_chk.sv @@
// Port-level checker for the LFU table, bound to the top level.
// Depends on lfu_pkg for the field widths.
module lfu_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic                         rsp_found,
	input logic [lfu_pkg::DATA_W-1:0]   rsp_read_value,
	input logic [lfu_pkg::EVICT_W-1:0]  rsp_evicted_count
);
	import lfu_pkg::*;

	// one request in flight: no second accept straight after the first
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in progress");

	// a response without a hit returns no data
	a_miss_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_found |-> rsp_read_value == '0)
		else $error("read value non-zero without a hit");

	// eviction only happens for a new key
	a_evict_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_evicted_count != '0 |-> !rsp_found)
		else $error("eviction reported together with found");

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found)
			&& $stable(rsp_read_value) && $stable(rsp_evicted_count))
		else $error("response changed while stalled");

endmodule

bind lfu_cache_group_evict_unit lfu_chk u_lfu_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_found         (rsp.found),
	.rsp_read_value    (rsp.read_value),
	.rsp_evicted_count (rsp.evicted_count)
);
